[design/bgbu_pkg.sv]
// bar graph block updater package
// word types, drawing constants and the fixed column color table
// no dependencies
`default_nettype none

package bgbu_pkg;

    typedef struct packed {
        logic [3:0] column;
        logic [7:0] level;
    } t_in_word;

    typedef struct packed {
        logic [8:0]  block_x;
        logic [8:0]  block_y;
        logic [15:0] block_color;
        logic        last;
    } t_out_word;

    localparam logic [2:0]  TOP_ROW      = 3'd7;
    localparam logic [8:0]  X_OFFSET     = 9'd2;
    localparam logic [8:0]  Y_OFFSET     = 9'd18;
    localparam logic [15:0] ERASE_COLOR  = 16'hFFFF;
    localparam logic [3:0]  CFG_COLUMN   = 4'd7;

    // fixed RGB565 colors, slot seven comes from the config register
    function automatic logic [15:0] fixed_color(input logic [3:0] col);
        logic [15:0] c;
        case (col)
            4'd0:    c = 16'hF800;
            4'd1:    c = 16'hFB80;
            4'd2:    c = 16'hFFE0;
            4'd3:    c = 16'h1FE0;
            4'd4:    c = 16'h03E0;
            4'd5:    c = 16'h0E1F;
            4'd6:    c = 16'h03FF;
            4'd8:    c = 16'h781F;
            4'd9:    c = 16'hF80F;
            default: c = 16'h0000;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[design/bgbu_level_store.sv]
// per-column level store for the bar graph block updater
// one read port, one write port, cleared by reset; uses no package
`default_nettype none

module bgbu_level_store #(
    parameter int NUM_COLUMNS = 10,
    parameter int IDX_W       = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_rd_idx,
    output logic      [2:0]       o_rd_level,
    input  wire logic             i_wr_en,
    input  wire logic [IDX_W-1:0] i_wr_idx,
    input  wire logic [2:0]       i_wr_level
);

    logic [2:0] r_levels [NUM_COLUMNS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COLUMNS; i++) begin
                r_levels[i] <= 3'd0;
            end
        end else if (i_wr_en) begin
            r_levels[i_wr_idx] <= i_wr_level;
        end
    end

    assign o_rd_level = r_levels[i_rd_idx];

endmodule

`default_nettype wire

[design/bar_graph_block_updater_top.sv]
// bar graph block updater, top level
// sequencer, block command generator and output register
// depends on bgbu_pkg and bgbu_level_store
`default_nettype none

//  channel | direction | handshake           | word
//  --------+-----------+---------------------+---------------------------
//  in      | input     | i_in_valid/o_in_stall | t_in_word (column, level)
//  out     | output    | o_out_valid/i_out_stall | t_out_word (x, y, color, last)
//  cfg     | input     | i_cfg_valid/o_cfg_ready | column seven color
//
//  an update takes the word, then compares it against the stored level, then
//  issues the block commands, one per changed segment (0..7), each gated by the
//  single output register. unchanged levels give no word; a column beyond the
//  store is dropped at the take, so that word never leaves the idle step
//  reset (synchronous, active low) clears all stored levels, the config color
//  and the sequencer. a stall on the out side holds the sequencer in its emit
//  step; the in side stalls whenever an update is in progress.

module bar_graph_block_updater_top #(
    parameter int NUM_COLUMNS = 10,
    parameter int MAX_LEVEL   = 7
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire bgbu_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output bgbu_pkg::t_out_word      o_out_word,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [15:0]         i_cfg_data
);

    import bgbu_pkg::*;

    localparam int IDX_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EMIT
    } t_state;

    t_state      r_state, n_state;
    logic [3:0]  r_col, n_col;
    logic [2:0]  r_lvl, n_lvl;
    logic [2:0]  r_seg, n_seg;
    logic [2:0]  r_hi, n_hi;
    logic [15:0] r_color, n_color;
    logic [15:0] r_cfg_color, n_cfg_color;
    t_out_word   r_out, n_out;
    logic        r_out_valid, n_out_valid;

    logic [2:0]  w_prev;
    logic        w_wr_en;
    logic        w_in_take;
    logic        w_out_free;
    logic [2:0]  w_row;
    logic        w_last;

    // previous level of every column
    bgbu_level_store #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .IDX_W       (IDX_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (r_col[IDX_W-1:0]),
        .o_rd_level (w_prev),
        .i_wr_en    (w_wr_en),
        .i_wr_idx   (r_col[IDX_W-1:0]),
        .i_wr_level (r_lvl)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign w_in_take  = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_wr_en    = (r_state == S_CMP) && (w_prev != r_lvl);
    assign w_row      = TOP_ROW - r_seg;
    assign w_last     = (3'(r_seg + 3'd1) == r_hi);

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_lvl       = r_lvl;
        n_seg       = r_seg;
        n_hi        = r_hi;
        n_color     = r_color;
        n_cfg_color = r_cfg_color;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (i_cfg_valid) begin
            n_cfg_color = i_cfg_data;
        end

        // the consumer took the word
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_col = i_in_word.column;
                    // saturate level
                    if (i_in_word.level > 8'(MAX_LEVEL)) begin
                        n_lvl = 3'(MAX_LEVEL);
                    end else begin
                        n_lvl = i_in_word.level[2:0];
                    end
                    // columns beyond the store are dropped
                    if ({1'b0, i_in_word.column} < 5'(NUM_COLUMNS)) begin
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                if (w_prev == r_lvl) begin
                    n_state = S_IDLE;
                end else if (r_lvl > w_prev) begin
                    // rising: draw new segments in column color
                    n_seg   = w_prev;
                    n_hi    = r_lvl;
                    n_color = (r_col == CFG_COLUMN) ? r_cfg_color : fixed_color(r_col);
                    n_state = S_EMIT;
                end else begin
                    // falling: erase removed segments
                    n_seg   = r_lvl;
                    n_hi    = w_prev;
                    n_color = ERASE_COLOR;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out.block_x     = {r_col, 5'd0} + X_OFFSET;
                    n_out.block_y     = {1'b0, w_row, 5'd0} - Y_OFFSET;
                    n_out.block_color = r_color;
                    n_out.last        = w_last;
                    n_out_valid       = 1'b1;
                    if (w_last) begin
                        n_seg   = 3'd0;
                        n_state = S_IDLE;
                    end else begin
                        n_seg = 3'(r_seg + 3'd1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seg       <= 3'd0;
            r_cfg_color <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seg       <= n_seg;
            r_cfg_color <= n_cfg_color;
            r_out_valid <= n_out_valid;
        end
        r_col   <= n_col;
        r_lvl   <= n_lvl;
        r_hi    <= n_hi;
        r_color <= n_color;
        r_out   <= n_out;
    end

endmodule

`default_nettype wire
